### design/cyrillic_latin_transliterator_defines.svh
// Assertion macros used by the transliterator top level.
`ifndef CYRILLIC_LATIN_TRANSLITERATOR_DEFINES_SVH
`define CYRILLIC_LATIN_TRANSLITERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/clt_pkg.sv
// Types, constants and lookup functions for the Cyrillic/Latin transliterator.
`default_nettype none

package clt_pkg;

    // Queue depths (powers of two) and derived widths
    localparam int IQ_DEPTH = 2;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Input transfer payload
    typedef struct packed {
        logic [15:0] char_code;
        logic        end_of_text;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [15:0] out_code;
        logic        out_valid;
        logic        out_last;
    } out_res_t;

    // Character class found by the front end
    typedef enum logic [2:0] {
        CLS_OTHER = 3'd0,
        CLS_CYR   = 3'd1,
        CLS_YO_UP = 3'd2,
        CLS_YO_LO = 3'd3,
        CLS_APOS  = 3'd4,
        CLS_LAT   = 3'd5
    } char_cls_t;

    // One classified character; idx is the Cyrillic offset or the Latin letter number
    typedef struct packed {
        logic [15:0] code;
        char_cls_t   cls;
        logic        up;
        logic [5:0]  idx;
    } win_char_t;

    // Entry of the queue between front and back
    typedef struct packed {
        win_char_t ch;
        logic      eot;
    } cls_item_t;

    // Queue status seen by the neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Latin spelling of one Cyrillic letter, ch[0] first
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] ch;
    } lat_str_t;

    // ASCII codes used in lookahead and classification
    localparam logic [15:0] CH_UC_A  = 16'h0041;
    localparam logic [15:0] CH_UC_Z  = 16'h005A;
    localparam logic [15:0] CH_LC_A  = 16'h0061;
    localparam logic [15:0] CH_LC_Z  = 16'h007A;
    localparam logic [15:0] CH_H     = 16'h0068;
    localparam logic [15:0] CH_S     = 16'h0073;
    localparam logic [15:0] CH_C     = 16'h0063;
    localparam logic [15:0] CH_A     = 16'h0061;
    localparam logic [15:0] CH_E     = 16'h0065;
    localparam logic [15:0] CH_U     = 16'h0075;
    localparam logic [15:0] CH_I     = 16'h0069;
    localparam logic [15:0] CH_APOS  = 16'h0027;

    // Cyrillic range and special code points
    localparam logic [15:0] CY_FIRST = 16'h0410;
    localparam logic [15:0] CY_LAST  = 16'h044F;
    localparam logic [15:0] CY_YO_UP = 16'h0401;
    localparam logic [15:0] CY_YO_LO = 16'h0451;
    localparam logic [15:0] CY_HARD  = 16'h044A;

    // Lower-case Cyrillic targets of the lookahead letters
    localparam logic [15:0] CY_ZHE   = 16'h0436;
    localparam logic [15:0] CY_ZE    = 16'h0437;
    localparam logic [15:0] CY_KA    = 16'h043A;
    localparam logic [15:0] CY_HA    = 16'h0445;
    localparam logic [15:0] CY_TE    = 16'h0442;
    localparam logic [15:0] CY_TSE   = 16'h0446;
    localparam logic [15:0] CY_CHE   = 16'h0447;
    localparam logic [15:0] CY_YA    = 16'h044F;
    localparam logic [15:0] CY_YU    = 16'h044E;
    localparam logic [15:0] CY_YERU  = 16'h044B;
    localparam logic [15:0] CY_SHORT = 16'h0439;
    localparam logic [15:0] CY_SHA   = 16'h0448;
    localparam logic [15:0] CY_SHCHA = 16'h0449;
    localparam logic [15:0] CY_ES    = 16'h0441;
    localparam logic [15:0] CASE_OFS = 16'h0020;

    // Latin letter numbers of the lookahead letters
    localparam logic [4:0] LI_C = 5'd2;
    localparam logic [4:0] LI_K = 5'd10;
    localparam logic [4:0] LI_S = 5'd18;
    localparam logic [4:0] LI_T = 5'd19;
    localparam logic [4:0] LI_Y = 5'd24;
    localparam logic [4:0] LI_Z = 5'd25;

    // Latin spelling of U+0410..U+044F; idx[5] clear means upper case
    function automatic lat_str_t cyr_lat(input logic [5:0] idx);
        lat_str_t s;
        s.len = 2'd1;
        s.ch  = '0;
        case (idx[4:0])
            5'd0:  s.ch[0] = "a";
            5'd1:  s.ch[0] = "b";
            5'd2:  s.ch[0] = "v";
            5'd3:  s.ch[0] = "g";
            5'd4:  s.ch[0] = "d";
            5'd5:  s.ch[0] = "e";
            5'd6:  begin s.len = 2'd2; s.ch[0] = "z"; s.ch[1] = "h"; end
            5'd7:  s.ch[0] = "z";
            5'd8:  s.ch[0] = "i";
            5'd9:  s.ch[0] = "y";
            5'd10: s.ch[0] = "k";
            5'd11: s.ch[0] = "l";
            5'd12: s.ch[0] = "m";
            5'd13: s.ch[0] = "n";
            5'd14: s.ch[0] = "o";
            5'd15: s.ch[0] = "p";
            5'd16: s.ch[0] = "r";
            5'd17: s.ch[0] = "s";
            5'd18: s.ch[0] = "t";
            5'd19: s.ch[0] = "u";
            5'd20: s.ch[0] = "f";
            5'd21: begin s.len = 2'd2; s.ch[0] = "k"; s.ch[1] = "h"; end
            5'd22: begin s.len = 2'd2; s.ch[0] = "t"; s.ch[1] = "s"; end
            5'd23: begin s.len = 2'd2; s.ch[0] = "c"; s.ch[1] = "h"; end
            5'd24: begin s.len = 2'd2; s.ch[0] = "s"; s.ch[1] = "h"; end
            5'd25: begin s.len = 2'd3; s.ch[0] = "s"; s.ch[1] = "c"; s.ch[2] = "h"; end
            5'd26: s.ch[0] = "'";
            5'd27: begin s.len = 2'd2; s.ch[0] = "y"; s.ch[1] = "i"; end
            5'd28: s.len = 2'd0;
            5'd29: s.ch[0] = "e";
            5'd30: begin s.len = 2'd2; s.ch[0] = "y"; s.ch[1] = "u"; end
            5'd31: begin s.len = 2'd2; s.ch[0] = "y"; s.ch[1] = "a"; end
            default: s.ch[0] = "a";
        endcase
        // capitalize the first letter for the upper-case half
        if (!idx[5] && s.ch[0] >= "a" && s.ch[0] <= "z")
            s.ch[0] = s.ch[0] - 8'h20;
        return s;
    endfunction

    // Plain Latin letter to lower-case Cyrillic, zero where none
    function automatic logic [15:0] lat_plain(input logic [4:0] li);
        logic [15:0] r;
        case (li)
            5'd0:  r = 16'h0430;
            5'd1:  r = 16'h0431;
            5'd3:  r = 16'h0434;
            5'd4:  r = 16'h0435;
            5'd5:  r = 16'h0444;
            5'd6:  r = 16'h0433;
            5'd8:  r = 16'h0438;
            5'd11: r = 16'h043B;
            5'd12: r = 16'h043C;
            5'd13: r = 16'h043D;
            5'd14: r = 16'h043E;
            5'd15: r = 16'h043F;
            5'd17: r = 16'h0440;
            5'd20: r = 16'h0443;
            5'd21: r = 16'h0432;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/clt_front.sv
// Front end: takes input transfers and classifies each character.
`default_nettype none

module clt_front (
    input  wire logic               push,
    output logic                    full,
    input  wire clt_pkg::in_item_t  item,
    input  wire clt_pkg::q_stat_t   iq_stat,
    output logic                    iq_push,
    output clt_pkg::cls_item_t      iq_wdata
);
    import clt_pkg::*;

    logic [15:0] code;

    assign code    = item.char_code;
    assign full    = iq_stat.full;
    assign iq_push = push && !iq_stat.full;

    // Classify the character
    always_comb
    begin
        iq_wdata.eot     = item.end_of_text;
        iq_wdata.ch.code = code;
        iq_wdata.ch.cls  = CLS_OTHER;
        iq_wdata.ch.up   = 1'b0;
        iq_wdata.ch.idx  = '0;
        if (code >= CY_FIRST && code <= CY_LAST)
        begin
            iq_wdata.ch.cls = CLS_CYR;
            iq_wdata.ch.idx = 6'(code - CY_FIRST);
        end
        else if (code == CY_YO_UP)
        begin
            iq_wdata.ch.cls = CLS_YO_UP;
        end
        else if (code == CY_YO_LO)
        begin
            iq_wdata.ch.cls = CLS_YO_LO;
        end
        else if (code == CH_APOS)
        begin
            iq_wdata.ch.cls = CLS_APOS;
        end
        else if (code >= CH_UC_A && code <= CH_UC_Z)
        begin
            iq_wdata.ch.cls = CLS_LAT;
            iq_wdata.ch.up  = 1'b1;
            iq_wdata.ch.idx = 6'(code - CH_UC_A);
        end
        else if (code >= CH_LC_A && code <= CH_LC_Z)
        begin
            iq_wdata.ch.cls = CLS_LAT;
            iq_wdata.ch.idx = 6'(code - CH_LC_A);
        end
    end

endmodule

`default_nettype wire

### design/clt_iq.sv
// Short queue of classified characters between front and back.
`default_nettype none

module clt_iq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire clt_pkg::cls_item_t  wdata,
    input  wire logic                pop,
    output clt_pkg::cls_item_t       rdata,
    output clt_pkg::q_stat_t         stat
);
    import clt_pkg::*;

    cls_item_t          mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IQ_CW-1:0]   count_reg, count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == IQ_CW'(IQ_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

### design/clt_oq.sv
// Result queue that drives the output side.
`default_nettype none

module clt_oq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire clt_pkg::out_res_t  wdata,
    input  wire logic               pop,
    output clt_pkg::out_res_t       rdata,
    output clt_pkg::q_stat_t        stat
);
    import clt_pkg::*;

    out_res_t           mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0]   count_reg, count_next;

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == OQ_CW'(OQ_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

### design/clt_back.sv
// Back end: lookahead window, translation steps and result sequencing.
`default_nettype none

module clt_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire clt_pkg::cls_item_t  iq_rdata,
    input  wire clt_pkg::q_stat_t    iq_stat,
    output logic                     iq_pop,
    input  wire clt_pkg::q_stat_t    oq_stat,
    output logic                     oq_push,
    output clt_pkg::out_res_t        oq_wdata
);
    import clt_pkg::*;

    typedef enum logic [1:0] {
        ST_EVAL = 2'b01,
        ST_EMIT = 2'b10
    } st_t;

    st_t              state_reg, state_next;
    logic             act_reg, act_next;       // an item is loaded in the window
    logic             end_reg, end_next;       // loaded item ends the string
    logic [1:0]       cnt_reg, cnt_next;       // characters in the window
    logic [1:0]       len_reg, len_next;       // code units left to emit
    logic             pend_v_reg, pend_v_next; // one result held back for out_last
    win_char_t [2:0]  win_reg, win_next;
    logic [2:0][15:0] str_reg, str_next;
    logic [15:0]      pend_code_reg, pend_code_next;

    win_char_t        head;
    logic [4:0]       li;
    logic [15:0]      a_code, b_code, sh;
    logic             need_la, brk, finish;
    logic [1:0]       t_len, t_k;
    logic [2:0][15:0] t_str;

    assign head   = win_reg[0];
    assign li     = head.idx[4:0];
    assign a_code = (cnt_reg >= 2'd2) ? win_reg[1].code : 16'h0000;
    assign b_code = (cnt_reg == 2'd3) ? win_reg[2].code : 16'h0000;
    assign sh     = head.up ? CASE_OFS : 16'h0000;

    // Lookahead check: hold the window until the next character arrives
    assign need_la = (head.cls == CLS_LAT) &&
                     (li == LI_S || li == LI_Z || li == LI_K ||
                      li == LI_T || li == LI_C || li == LI_Y);
    assign brk     = !end_reg && need_la &&
                     ((cnt_reg < 2'd2) ||
                      (li == LI_S && a_code == CH_C && cnt_reg < 2'd3));
    assign finish  = act_reg && (cnt_reg == 2'd0 || brk);

    // Translate the head character
    always_comb
    begin
        lat_str_t cs;
        cs    = cyr_lat(head.idx);
        t_len = 2'd1;
        t_k   = 2'd1;
        t_str = {32'h0, head.code};
        case (head.cls)
            CLS_CYR:
            begin
                t_len = cs.len;
                t_str = {8'h00, cs.ch[2], 8'h00, cs.ch[1], 8'h00, cs.ch[0]};
            end
            CLS_YO_UP:
            begin
                t_len = 2'd2;
                t_str = {16'h0000, 16'(CH_E), 16'h0059};
            end
            CLS_YO_LO:
            begin
                t_len = 2'd2;
                t_str = {16'h0000, 16'(CH_E), 16'h0079};
            end
            CLS_APOS:
                t_str[0] = CY_HARD;
            CLS_LAT:
            begin
                case (li)
                    LI_Z:
                        if (a_code == CH_H)
                        begin
                            t_str[0] = CY_ZHE - sh;
                            t_k      = 2'd2;
                        end
                        else
                            t_str[0] = CY_ZE - sh;
                    LI_K:
                        if (a_code == CH_H)
                        begin
                            t_str[0] = CY_HA - sh;
                            t_k      = 2'd2;
                        end
                        else
                            t_str[0] = CY_KA - sh;
                    LI_T:
                        if (a_code == CH_S)
                        begin
                            t_str[0] = CY_TSE - sh;
                            t_k      = 2'd2;
                        end
                        else
                            t_str[0] = CY_TE - sh;
                    LI_C:
                        if (a_code == CH_H)
                        begin
                            t_str[0] = CY_CHE - sh;
                            t_k      = 2'd2;
                        end
                    LI_Y:
                    begin
                        t_k = 2'd2;
                        if (a_code == CH_A)
                            t_str[0] = CY_YA - sh;
                        else if (a_code == CH_E)
                            t_str[0] = head.up ? CY_YO_UP : CY_YO_LO;
                        else if (a_code == CH_U)
                            t_str[0] = CY_YU - sh;
                        else if (a_code == CH_I)
                            t_str[0] = CY_YERU - sh;
                        else
                        begin
                            t_str[0] = CY_SHORT - sh;
                            t_k      = 2'd1;
                        end
                    end
                    LI_S:
                        if (a_code == CH_H)
                        begin
                            t_str[0] = CY_SHA - sh;
                            t_k      = 2'd2;
                        end
                        else if (a_code == CH_C && b_code == CH_H)
                        begin
                            t_str[0] = CY_SHCHA - sh;
                            t_k      = 2'd3;
                        end
                        else
                            t_str[0] = CY_ES - sh;
                    default:
                        if (lat_plain(li) != 16'h0000)
                            t_str[0] = lat_plain(li) - sh;
                endcase
            end
            default:
                t_str[0] = head.code;
        endcase
    end

    // Sequencer
    always_comb
    begin
        logic can_go;
        can_go         = 1'b1;
        state_next     = state_reg;
        act_next       = act_reg;
        end_next       = end_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        pend_v_next    = pend_v_reg;
        win_next       = win_reg;
        str_next       = str_reg;
        pend_code_next = pend_code_reg;
        iq_pop         = 1'b0;
        oq_push        = 1'b0;
        oq_wdata       = '{out_code: pend_code_reg, out_valid: 1'b1, out_last: 1'b0};
        case (state_reg)
            ST_EVAL:
            begin
                if (act_reg && !finish)
                begin
                    // consume t_k characters from the window
                    case (t_k)
                        2'd1:
                        begin
                            win_next[0] = win_reg[1];
                            win_next[1] = win_reg[2];
                        end
                        2'd2:
                            win_next[0] = win_reg[2];
                        default:
                            win_next = win_reg;
                    endcase
                    cnt_next = cnt_reg - t_k;
                    if (t_len != 2'd0)
                    begin
                        str_next   = t_str;
                        len_next   = t_len;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    // close the item: release the held result or an end marker
                    if (act_reg)
                    begin
                        if (end_reg || pend_v_reg)
                        begin
                            if (oq_stat.full)
                                can_go = 1'b0;
                            else
                            begin
                                oq_push           = 1'b1;
                                oq_wdata.out_last = end_reg;
                                if (!pend_v_reg)
                                begin
                                    oq_wdata.out_code  = 16'h0000;
                                    oq_wdata.out_valid = 1'b0;
                                end
                            end
                        end
                        if (can_go)
                        begin
                            act_next    = 1'b0;
                            pend_v_next = 1'b0;
                        end
                    end
                    // load the next character behind the held ones
                    if (can_go && !iq_stat.empty)
                    begin
                        iq_pop            = 1'b1;
                        win_next[cnt_reg] = iq_rdata.ch;
                        cnt_next          = cnt_reg + 1'b1;
                        end_next          = iq_rdata.eot;
                        act_next          = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!(pend_v_reg && oq_stat.full))
                begin
                    oq_push        = pend_v_reg;
                    pend_code_next = str_reg[0];
                    pend_v_next    = 1'b1;
                    str_next       = {16'h0000, str_reg[2:1]};
                    len_next       = len_reg - 1'b1;
                    if (len_reg == 2'd1)
                        state_next = ST_EVAL;
                end
            end
            default:
                state_next = ST_EVAL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_EVAL;
            act_reg    <= 1'b0;
            end_reg    <= 1'b0;
            cnt_reg    <= 2'd0;
            len_reg    <= 2'd0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            end_reg    <= end_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            pend_v_reg <= pend_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        str_reg       <= str_next;
        pend_code_reg <= pend_code_next;
    end

endmodule

`default_nettype wire

### design/cyrillic_latin_transliterator.sv
// Top level of the streaming Russian Cyrillic/Latin transliterator.
//
//   channel   ports                    payload    handshake
//   -------   ----------------------   --------   ---------------------------
//   input     push, full, item         in_item_t  transfer on push & !full
//   result    empty, pop, result       out_res_t  transfer on pop & !empty
//
// The back sequencer does one translation step per cycle when not emitting and
// writes one code unit per cycle while the result queue is not full; it closes
// an item and loads the next one in a single sequencer step.
// A two-deep item queue and a four-deep result queue let both sides stall
// independently; full rises only when the item queue is full.
// rst_n is asynchronous: queues empty, no lookahead held.
`default_nettype none
`include "cyrillic_latin_transliterator_defines.svh"

module cyrillic_latin_transliterator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire clt_pkg::in_item_t  item,
    output logic                    empty,
    input  wire logic               pop,
    output clt_pkg::out_res_t       result
);
    import clt_pkg::*;

    logic      iq_push, iq_pop, oq_push;
    cls_item_t iq_wdata, iq_rdata;
    out_res_t  oq_wdata;
    q_stat_t   iq_stat, oq_stat;

    // Front end
    clt_front u_front (
        .push     (push),
        .full     (full),
        .item     (item),
        .iq_stat  (iq_stat),
        .iq_push  (iq_push),
        .iq_wdata (iq_wdata)
    );

    // Queue between front and back
    clt_iq u_iq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (iq_push),
        .wdata (iq_wdata),
        .pop   (iq_pop),
        .rdata (iq_rdata),
        .stat  (iq_stat)
    );

    // Back end
    clt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .iq_rdata (iq_rdata),
        .iq_stat  (iq_stat),
        .iq_pop   (iq_pop),
        .oq_stat  (oq_stat),
        .oq_push  (oq_push),
        .oq_wdata (oq_wdata)
    );

    // Result queue
    clt_oq u_oq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata (oq_wdata),
        .pop   (pop && !oq_stat.empty),
        .rdata (result),
        .stat  (oq_stat)
    );

    assign empty = oq_stat.empty;

    // Checks
    `CLT_ASSERT_NEXT(a_item_queued, push && !full, !iq_stat.empty, "accepted item not queued")
    `CLT_ASSERT_IMPL(a_oq_no_overflow, oq_push, !oq_stat.full, "result queue overflow")
    `CLT_ASSERT_IMPL(a_marker_last, !empty && !result.out_valid, result.out_last && result.out_code == 16'h0000, "bad end marker")

endmodule

`default_nettype wire
